>>> rtl/kfnn_pkg.sv
// ----------------------------------------------------------------------------
// kfnn_pkg
// shared constants and command codes of the keyframe nearest-neighbor search
// ----------------------------------------------------------------------------
package kfnn_pkg;
    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = 6;
    localparam int CNT_W         = 7;
    localparam int COORD_W       = 16;
    localparam int DIST_W        = 17;
    localparam int KEY_W         = DIST_W + IDX_W;
    localparam int SQ_W          = 33;

    localparam logic [2:0] CMD_LOAD     = 3'd0;
    localparam logic [2:0] CMD_NEAR_REF = 3'd1;
    localparam logic [2:0] CMD_NEAR_SLM = 3'd2;
    localparam logic [2:0] CMD_RADIUS   = 3'd3;
    localparam logic [2:0] CMD_KNN      = 3'd4;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    typedef struct packed {
        logic            start;
        logic [SQ_W-1:0] value;
    } sqrt_req_t;
endpackage

>>> rtl/kfnn_isqrt.sv
// ----------------------------------------------------------------------------
// kfnn_isqrt
// iterative truncated square root, one result bit per cycle
// ----------------------------------------------------------------------------
module kfnn_isqrt (
    input  logic                     clk,
    input  logic                     rst_n,
    input  kfnn_pkg::sqrt_req_t      req,
    output logic                     done,
    output logic [kfnn_pkg::DIST_W-1:0] root
);
    import kfnn_pkg::*;

    logic [SQ_W-1:0] n_reg, n_next;
    logic [SQ_W-1:0] r_reg, r_next;
    logic [SQ_W-1:0] bit_reg, bit_next;
    logic            run_reg, run_next;
    logic            done_reg, done_next;
    logic [SQ_W-1:0] trial;

    assign trial = r_reg + bit_reg;

    always_comb
    begin
        n_next    = n_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            n_next   = req.value;
            r_next   = '0;
            bit_next = {1'b1, {(SQ_W-1){1'b0}}};
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (n_reg >= trial)
            begin
                n_next = n_reg - trial;
                r_next = (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = r_reg[DIST_W-1:0];
endmodule

>>> rtl/keyframe_nearest_neighbor_search.sv
// ----------------------------------------------------------------------------
// keyframe_nearest_neighbor_search
// brute-force 2-d nearest-neighbor search over a 64-entry keyframe table
// ----------------------------------------------------------------------------
// usage:
//   a transaction is accepted when start is high and busy is low. results
//   appear on found_entry, distance, status and last for one cycle each,
//   marked by valid; the receiver cannot stall them. last marks the final
//   result of a command.
//   a load, or an unknown command, gives its single result in the cycle
//   after acceptance and leaves busy low.
//   queries scan the table in index order; each present entry passes
//   through scan, squares, sum, the square root unit and update, while
//   an absent one is skipped in the scan state alone.
//   the k-nearest query then runs one selection pass over the stored keys
//   per result, reading and comparing each stored key in turn, then
//   emitting the smallest key not yet given.
//   the square root unit sets the pace of the scan, the key memory, read
//   one key at a time, that of the selection.
//   reset clears the present marks and the control state; point and key
//   memories hold no reset value and need no clearing pass.
// ----------------------------------------------------------------------------
module keyframe_nearest_neighbor_search (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   command,
    input  logic [kfnn_pkg::IDX_W-1:0]   entry,
    input  logic                         entry_present,
    input  logic signed [15:0]           point_x,
    input  logic signed [15:0]           point_y,
    input  logic signed [15:0]           slam_x,
    input  logic signed [15:0]           slam_y,
    input  logic [kfnn_pkg::DIST_W-1:0]  radius,
    input  logic [kfnn_pkg::CNT_W-1:0]   count_k,
    output logic                         valid,
    output logic [kfnn_pkg::IDX_W-1:0]   found_entry,
    output logic [kfnn_pkg::DIST_W-1:0]  distance,
    output logic                         status,
    output logic                         last
);
    import kfnn_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_SUM  = 4'd3;
    localparam logic [3:0] S_SQRT = 4'd4;
    localparam logic [3:0] S_UPD  = 4'd5;
    localparam logic [3:0] S_KRD  = 4'd6;
    localparam logic [3:0] S_KCMP = 4'd7;
    localparam logic [3:0] S_KEMIT = 4'd8;

    localparam logic [CNT_W-1:0] TABLE_END = CNT_W'(TABLE_ENTRIES);
    localparam logic [KEY_W-1:0] KEY_NONE  = '1;
    localparam logic [DIST_W-1:0] DIST_ONE = DIST_W'(16);

    logic [63:0]      point_mem [TABLE_ENTRIES];
    logic [KEY_W-1:0] key_mem   [TABLE_ENTRIES];
    logic [63:0]      rd_q_reg;
    logic [KEY_W-1:0] key_q_reg;

    logic [TABLE_ENTRIES-1:0] present_reg, present_next;
    logic [3:0]        state_reg, state_next;
    logic [2:0]        cmd_reg, cmd_next;
    logic [15:0]       qx_reg, qx_next, qy_reg, qy_next;
    logic [DIST_W-1:0] radius_reg, radius_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [31:0]       dx2_reg, dx2_next, dy2_reg, dy2_next;
    logic              found_reg, found_next;
    logic [DIST_W-1:0] best_d_reg, best_d_next;
    logic [IDX_W-1:0]  best_i_reg, best_i_next;
    logic              pend_reg, pend_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [KEY_W-1:0]  prev_reg, prev_next;
    logic              have_prev_reg, have_prev_next;
    logic [KEY_W-1:0]  min_reg, min_next;
    logic [CNT_W-1:0]  emitted_reg, emitted_next;
    logic              valid_reg, valid_next;
    logic [IDX_W-1:0]  found_entry_reg, found_entry_next;
    logic [DIST_W-1:0] distance_reg, distance_next;
    logic              status_reg, status_next;
    logic              last_reg, last_next;

    logic              accept;
    logic              load_wr;
    logic              key_wr;
    logic [31:0]       sel;
    logic signed [16:0] dx, dy;
    logic signed [33:0] px2, py2;
    logic [CNT_W-1:0]  emitted_inc;
    sqrt_req_t         sq_req;
    logic              sq_done;
    logic [DIST_W-1:0] sq_root;

    kfnn_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sq_req),
        .done  (sq_done),
        .root  (sq_root)
    );

    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && !busy;
    assign load_wr = accept && (command == CMD_LOAD) && entry_present
                     && ({1'b0, entry} < TABLE_END);
    assign key_wr  = (state_reg == S_UPD) && (cmd_reg == CMD_KNN);

    assign sel = (cmd_reg == CMD_NEAR_SLM) ? rd_q_reg[63:32] : rd_q_reg[31:0];
    assign dx  = $signed({sel[15], sel[15:0]}) - $signed({qx_reg[15], qx_reg});
    assign dy  = $signed({sel[31], sel[31:16]}) - $signed({qy_reg[15], qy_reg});
    assign px2 = dx * dx;
    assign py2 = dy * dy;
    assign emitted_inc = emitted_reg + CNT_W'(1);

    assign sq_req.start = (state_reg == S_SUM);
    assign sq_req.value = {1'b0, dx2_reg} + {1'b0, dy2_reg};

    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            point_mem[entry] <= {slam_y, slam_x, point_y, point_x};
        end
        rd_q_reg <= point_mem[idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (key_wr)
        begin
            key_mem[cnt_reg[IDX_W-1:0]] <= {sq_root, idx_reg[IDX_W-1:0]};
        end
        key_q_reg <= key_mem[j_reg[IDX_W-1:0]];
    end

    always_comb
    begin
        present_next     = present_reg;
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        qx_next          = qx_reg;
        qy_next          = qy_reg;
        radius_next      = radius_reg;
        k_next           = k_reg;
        idx_next         = idx_reg;
        dx2_next         = dx2_reg;
        dy2_next         = dy2_reg;
        found_next       = found_reg;
        best_d_next      = best_d_reg;
        best_i_next      = best_i_reg;
        pend_next        = pend_reg;
        cnt_next         = cnt_reg;
        j_next           = j_reg;
        prev_next        = prev_reg;
        have_prev_next   = have_prev_reg;
        min_next         = min_reg;
        emitted_next     = emitted_reg;
        valid_next       = 1'b0;
        found_entry_next = found_entry_reg;
        distance_next    = distance_reg;
        status_next      = status_reg;
        last_next        = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = command;
                    qx_next     = point_x;
                    qy_next     = point_y;
                    radius_next = radius;
                    k_next      = count_k;
                    idx_next    = '0;
                    found_next  = 1'b0;
                    pend_next   = 1'b0;
                    cnt_next    = '0;
                    case (command)
                        CMD_LOAD:
                        begin
                            valid_next       = 1'b1;
                            found_entry_next = entry;
                            distance_next    = '0;
                            last_next        = 1'b1;
                            if ({1'b0, entry} < TABLE_END)
                            begin
                                present_next[entry] = entry_present;
                                status_next         = STATUS_OK;
                            end
                            else
                            begin
                                status_next = STATUS_ERROR;
                            end
                        end
                        CMD_NEAR_REF, CMD_NEAR_SLM, CMD_RADIUS, CMD_KNN:
                        begin
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            valid_next       = 1'b1;
                            found_entry_next = '0;
                            distance_next    = '0;
                            status_next      = STATUS_ERROR;
                            last_next        = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (idx_reg == TABLE_END)
                begin
                    state_next       = S_IDLE;
                    valid_next       = 1'b1;
                    last_next        = 1'b1;
                    found_entry_next = '0;
                    distance_next    = '0;
                    status_next      = STATUS_ERROR;
                    case (cmd_reg)
                        CMD_NEAR_REF, CMD_NEAR_SLM, CMD_RADIUS:
                        begin
                            if (found_reg || pend_reg)
                            begin
                                found_entry_next = best_i_reg;
                                distance_next    = best_d_reg;
                                status_next      = STATUS_OK;
                            end
                        end
                        default:
                        begin
                            if (k_reg != '0 && cnt_reg != '0)
                            begin
                                valid_next     = 1'b0;
                                state_next     = S_KRD;
                                j_next         = '0;
                                min_next       = KEY_NONE;
                                have_prev_next = 1'b0;
                                emitted_next   = '0;
                            end
                        end
                    endcase
                end
                else if (present_reg[idx_reg[IDX_W-1:0]])
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            S_MUL:
            begin
                dx2_next   = px2[31:0];
                dy2_next   = py2[31:0];
                state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (sq_done)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                case (cmd_reg)
                    CMD_NEAR_REF, CMD_NEAR_SLM:
                    begin
                        if (!found_reg || sq_root < best_d_reg)
                        begin
                            found_next  = 1'b1;
                            best_d_next = sq_root;
                            best_i_next = idx_reg[IDX_W-1:0];
                        end
                    end
                    CMD_RADIUS:
                    begin
                        if (sq_root < radius_reg)
                        begin
                            if (pend_reg)
                            begin
                                valid_next       = 1'b1;
                                found_entry_next = best_i_reg;
                                distance_next    = best_d_reg;
                                status_next      = STATUS_OK;
                                last_next        = 1'b0;
                            end
                            pend_next   = 1'b1;
                            best_d_next = sq_root;
                            best_i_next = idx_reg[IDX_W-1:0];
                        end
                    end
                    default:
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                endcase
                idx_next   = idx_reg + CNT_W'(1);
                state_next = S_SCAN;
            end
            S_KRD:
            begin
                state_next = S_KCMP;
            end
            S_KCMP:
            begin
                if ((!have_prev_reg || key_q_reg > prev_reg) && key_q_reg < min_reg)
                begin
                    min_next = key_q_reg;
                end
                j_next = j_reg + CNT_W'(1);
                if (j_next == cnt_reg)
                begin
                    state_next = S_KEMIT;
                end
                else
                begin
                    state_next = S_KRD;
                end
            end
            S_KEMIT:
            begin
                valid_next       = 1'b1;
                found_entry_next = min_reg[IDX_W-1:0];
                status_next      = STATUS_OK;
                if (emitted_reg == '0 && min_reg[KEY_W-1:IDX_W] == '0)
                begin
                    distance_next = DIST_ONE;
                    last_next     = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    distance_next = min_reg[KEY_W-1:IDX_W];
                    if (emitted_inc == k_reg || emitted_inc == cnt_reg)
                    begin
                        last_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        last_next      = 1'b0;
                        state_next     = S_KRD;
                        prev_next      = min_reg;
                        have_prev_next = 1'b1;
                        min_next       = KEY_NONE;
                        j_next         = '0;
                        emitted_next   = emitted_inc;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            present_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            present_reg <= present_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        qx_reg          <= qx_next;
        qy_reg          <= qy_next;
        radius_reg      <= radius_next;
        k_reg           <= k_next;
        idx_reg         <= idx_next;
        dx2_reg         <= dx2_next;
        dy2_reg         <= dy2_next;
        found_reg       <= found_next;
        best_d_reg      <= best_d_next;
        best_i_reg      <= best_i_next;
        pend_reg        <= pend_next;
        cnt_reg         <= cnt_next;
        j_reg           <= j_next;
        prev_reg        <= prev_next;
        have_prev_reg   <= have_prev_next;
        min_reg         <= min_next;
        emitted_reg     <= emitted_next;
        found_entry_reg <= found_entry_next;
        distance_reg    <= distance_next;
        status_reg      <= status_next;
        last_reg        <= last_next;
    end

    assign valid       = valid_reg;
    assign found_entry = found_entry_reg;
    assign distance    = distance_reg;
    assign status      = status_reg;
    assign last        = last_reg;

    // a query ends only with its final result
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> valid && last)
        else $error("query ended without final result");

    // error results are always final
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && status |-> last)
        else $error("error result not final");

    // a non-final result means more work is pending
    a_more: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !last |-> busy)
        else $error("non-final result while idle");

    // square root is only started during a scan
    a_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
        sq_req.start |=> (state_reg == S_SQRT))
        else $error("square root started out of sequence");
endmodule

>>> sim/kfnn_match_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kfnn_match_monitor
// watches the command and result channels of the keyframe nearest-neighbor
// search, keeps its own copy of the keyframe table, works out the matches
// every accepted command must give and compares each result field by field
// ----------------------------------------------------------------------------
module kfnn_match_monitor (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [2:0]                  command,
    input  logic [kfnn_pkg::IDX_W-1:0]  entry,
    input  logic                        entry_present,
    input  logic signed [15:0]          point_x,
    input  logic signed [15:0]          point_y,
    input  logic signed [15:0]          slam_x,
    input  logic signed [15:0]          slam_y,
    input  logic [kfnn_pkg::DIST_W-1:0] radius,
    input  logic [kfnn_pkg::CNT_W-1:0]  count_k,
    input  logic                        valid,
    input  logic [kfnn_pkg::IDX_W-1:0]  found_entry,
    input  logic [kfnn_pkg::DIST_W-1:0] distance,
    input  logic                        status,
    input  logic                        last,
    output int                          errors,
    output int                          pending
);
    import kfnn_pkg::*;

    typedef struct {
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] dist_val;
        logic              stat;
        logic              fin;
    } match_t;

    logic signed [15:0] ref_x [TABLE_ENTRIES];
    logic signed [15:0] ref_y [TABLE_ENTRIES];
    logic signed [15:0] slm_x [TABLE_ENTRIES];
    logic signed [15:0] slm_y [TABLE_ENTRIES];
    logic               present [TABLE_ENTRIES];
    match_t             expected_matches [$];

    initial errors = 0;
    assign pending = expected_matches.size();

    function automatic logic [DIST_W-1:0] euclid(logic signed [15:0] ax, logic signed [15:0] ay,
                                                 logic signed [15:0] bx, logic signed [15:0] by);
        longint dx;
        longint dy;
        longint unsigned n;
        longint unsigned r;
        longint unsigned b;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        n = longint'(dx * dx + dy * dy);
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r[DIST_W-1:0];
    endfunction

    function automatic match_t mk(int i, int d, logic s, logic f);
        match_t m;
        m.idx      = i[IDX_W-1:0];
        m.dist_val = d[DIST_W-1:0];
        m.stat     = s;
        m.fin      = f;
        return m;
    endfunction

    task automatic predict_command();
        logic [KEY_W-1:0] keys [$];
        logic [KEY_W-1:0] key;
        logic [DIST_W-1:0] d;
        logic [DIST_W-1:0] best;
        int bidx;
        int n;
        int take;
        int j;
        n = 0;
        bidx = -1;
        best = '0;
        case (command)
            CMD_LOAD:
            begin
                if (entry_present)
                begin
                    ref_x[entry] = point_x;
                    ref_y[entry] = point_y;
                    slm_x[entry] = slam_x;
                    slm_y[entry] = slam_y;
                end
                present[entry] = entry_present;
                expected_matches.push_back(mk(entry, 0, STATUS_OK, 1'b1));
            end
            CMD_NEAR_REF, CMD_NEAR_SLM:
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (!present[i])
                        continue;
                    d = (command == CMD_NEAR_REF) ?
                        euclid(ref_x[i], ref_y[i], point_x, point_y) :
                        euclid(slm_x[i], slm_y[i], point_x, point_y);
                    if (bidx < 0 || d < best)
                    begin
                        bidx = i;
                        best = d;
                    end
                end
                if (bidx < 0)
                    expected_matches.push_back(mk(0, 0, STATUS_ERROR, 1'b1));
                else
                    expected_matches.push_back(mk(bidx, best, STATUS_OK, 1'b1));
            end
            CMD_RADIUS:
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (!present[i])
                        continue;
                    d = euclid(ref_x[i], ref_y[i], point_x, point_y);
                    if (d < radius)
                    begin
                        expected_matches.push_back(mk(i, d, STATUS_OK, 1'b0));
                        n++;
                    end
                end
                if (n == 0)
                    expected_matches.push_back(mk(0, 0, STATUS_ERROR, 1'b1));
                else
                    expected_matches[$].fin = 1'b1;
            end
            CMD_KNN:
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (!present[i])
                        continue;
                    key = {euclid(ref_x[i], ref_y[i], point_x, point_y), i[IDX_W-1:0]};
                    j = 0;
                    while (j < keys.size() && keys[j] < key)
                        j++;
                    keys.insert(j, key);
                end
                if (count_k == 0 || keys.size() == 0)
                    expected_matches.push_back(mk(0, 0, STATUS_ERROR, 1'b1));
                else if (keys[0][KEY_W-1:IDX_W] == 0)
                    expected_matches.push_back(mk(keys[0][IDX_W-1:0], 16, STATUS_OK, 1'b1));
                else
                begin
                    take = (keys.size() < count_k) ? keys.size() : count_k;
                    for (int i = 0; i < take; i++)
                        expected_matches.push_back(mk(keys[i][IDX_W-1:0],
                            keys[i][KEY_W-1:IDX_W], STATUS_OK, i == take - 1));
                end
            end
            default:
                expected_matches.push_back(mk(0, 0, STATUS_ERROR, 1'b1));
        endcase
    endtask

    task automatic report_mismatch(string what, int want, int got);
        $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, want, got);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        match_t m;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
                present[i] = 1'b0;
        end
        else
        begin
            if (valid)
            begin
                if (expected_matches.size() == 0)
                    report_mismatch("unexpected result entry", -1, found_entry);
                else
                begin
                    m = expected_matches.pop_front();
                    if (found_entry !== m.idx)
                        report_mismatch("found_entry", m.idx, found_entry);
                    if (distance !== m.dist_val)
                        report_mismatch("distance", m.dist_val, distance);
                    if (status !== m.stat)
                        report_mismatch("status", m.stat, status);
                    if (last !== m.fin)
                        report_mismatch("last", m.fin, last);
                end
            end
            if (start && !busy)
                predict_command();
        end
    end

    final
    begin
    end
endmodule

>>> sim/tb_keyframe_nearest_neighbor_search.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyframe_nearest_neighbor_search
// drives loads and queries into the keyframe search: a directed set of corner
// cases, then random traffic over clustered and extreme points with random
// idle bursts; a monitor predicts and checks every result
// ----------------------------------------------------------------------------
module tb_keyframe_nearest_neighbor_search;
    import kfnn_pkg::*;

    localparam int STALL_LIMIT = 40000;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [2:0]          command;
    logic [IDX_W-1:0]    entry;
    logic                entry_present;
    logic signed [15:0]  point_x;
    logic signed [15:0]  point_y;
    logic signed [15:0]  slam_x;
    logic signed [15:0]  slam_y;
    logic [DIST_W-1:0]   radius;
    logic [CNT_W-1:0]    count_k;
    logic                valid;
    logic [IDX_W-1:0]    found_entry;
    logic [DIST_W-1:0]   distance;
    logic                status;
    logic                last;
    int                  errors;
    int                  pending;
    int                  stall_cycles;
    bit                  quiet;
    logic signed [15:0]  known_x [$];
    logic signed [15:0]  known_y [$];

    keyframe_nearest_neighbor_search dut (.*);

    kfnn_match_monitor monitor (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if ((start && !busy) || valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic signed [15:0] pick_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 16'((int'($urandom_range(0, 16)) - 8) * 16);
            8:             return 16'sh8000;
            9:             return 16'sh7fff;
            default:       return 16'($urandom);
        endcase
    endfunction

    task automatic issue(logic [2:0] cmd, int ent, logic pres, logic signed [15:0] px,
                         logic signed [15:0] py, logic signed [15:0] sx,
                         logic signed [15:0] sy, int rad, int k);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        start         <= 1'b1;
        command       <= cmd;
        entry         <= ent[IDX_W-1:0];
        entry_present <= pres;
        point_x       <= px;
        point_y       <= py;
        slam_x        <= sx;
        slam_y        <= sy;
        radius        <= rad[DIST_W-1:0];
        count_k       <= k[CNT_W-1:0];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (cmd == CMD_LOAD && pres)
        begin
            known_x.push_back(px);
            known_y.push_back(py);
        end
    endtask

    task automatic random_item();
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        int rad;
        int k;
        int sel;
        qx = pick_coord();
        qy = pick_coord();
        if (known_x.size() > 0 && $urandom_range(0, 2) == 0)
        begin
            sel = $urandom_range(0, known_x.size() - 1);
            qx = known_x[sel];
            qy = known_y[sel];
        end
        case ($urandom_range(0, 3))
            0:       rad = 0;
            1:       rad = $urandom_range(1, 400);
            2:       rad = $urandom_range(0, 92682);
            default: rad = $urandom_range(0, 131071);
        endcase
        case ($urandom_range(0, 9))
            0:       k = $urandom_range(0, 127);
            1, 2:    k = $urandom_range(1, 64);
            default: k = $urandom_range(1, 8);
        endcase
        sel = $urandom_range(0, 99);
        if (sel < 38)
            issue(CMD_LOAD, $urandom_range(0, 63), $urandom_range(0, 3) != 0, qx, qy,
                  pick_coord(), pick_coord(), rad, k);
        else if (sel < 53)
            issue(CMD_NEAR_REF, $urandom_range(0, 63), $urandom_range(0, 1), qx, qy,
                  16'($urandom), 16'($urandom), rad, k);
        else if (sel < 66)
            issue(CMD_NEAR_SLM, $urandom_range(0, 63), $urandom_range(0, 1), qx, qy,
                  16'($urandom), 16'($urandom), rad, k);
        else if (sel < 80)
            issue(CMD_RADIUS, $urandom_range(0, 63), $urandom_range(0, 1), qx, qy,
                  16'($urandom), 16'($urandom), rad, k);
        else if (sel < 97)
            issue(CMD_KNN, $urandom_range(0, 63), $urandom_range(0, 1), qx, qy,
                  16'($urandom), 16'($urandom), rad, k);
        else
            issue(3'($urandom_range(5, 7)), $urandom_range(0, 63), $urandom_range(0, 1),
                  qx, qy, 16'($urandom), 16'($urandom), rad, k);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        command       = CMD_LOAD;
        entry         = '0;
        entry_present = 1'b0;
        point_x       = '0;
        point_y       = '0;
        slam_x        = '0;
        slam_y        = '0;
        radius        = '0;
        count_k       = '0;
        stall_cycles  = 0;
        quiet         = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table
        issue(CMD_NEAR_REF, 0, 0, 0, 0, 0, 0, 0, 1);
        issue(CMD_KNN, 0, 0, 0, 0, 0, 0, 0, 5);
        issue(CMD_RADIUS, 0, 0, 0, 0, 0, 0, 131071, 1);
        // extremes and ties
        issue(CMD_LOAD, 0, 1, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 0, 0);
        issue(CMD_LOAD, 63, 1, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 0, 0);
        issue(CMD_LOAD, 21, 1, 16'sh0100, 16'sh0100, 0, 0, 0, 0);
        issue(CMD_LOAD, 42, 1, 16'sh0100, 16'sh0100, 16'sh0010, 16'shfff0, 0, 0);
        issue(CMD_NEAR_REF, 0, 0, 16'sh7fff, 16'sh7fff, 0, 0, 0, 0);
        issue(CMD_NEAR_REF, 0, 0, 16'sh0000, 16'sh0000, 0, 0, 0, 0);
        issue(CMD_NEAR_SLM, 0, 0, 16'sh8000, 16'sh8000, 0, 0, 0, 0);
        issue(CMD_NEAR_SLM, 0, 0, 16'sh0000, 16'sh0000, 0, 0, 0, 0);
        issue(CMD_RADIUS, 0, 0, 16'sh8000, 16'sh8000, 0, 0, 0, 0);
        issue(CMD_RADIUS, 0, 0, 16'sh8000, 16'sh8000, 0, 0, 131071, 0);
        issue(CMD_RADIUS, 0, 0, 16'sh8000, 16'sh8000, 0, 0, 92680, 0);
        issue(CMD_KNN, 0, 0, 16'sh0000, 16'sh0000, 0, 0, 0, 0);
        issue(CMD_KNN, 0, 0, 16'sh0000, 16'sh0000, 0, 0, 0, 127);
        issue(CMD_KNN, 0, 0, 16'sh0000, 16'sh0000, 0, 0, 0, 64);
        issue(CMD_KNN, 0, 0, 16'sh0100, 16'sh0100, 0, 0, 0, 3);
        issue(CMD_KNN, 0, 0, 16'sh7fff, 16'sh8000, 0, 0, 0, 1);
        issue(3'd5, 0, 0, 0, 0, 0, 0, 0, 0);
        issue(3'd6, 0, 0, 0, 0, 0, 0, 0, 0);
        issue(3'd7, 63, 1, 16'shffff, 16'shffff, 16'shffff, 16'shffff, 131071, 127);
        issue(CMD_LOAD, 21, 0, 0, 0, 0, 0, 0, 0);
        issue(CMD_NEAR_REF, 0, 0, 16'sh0100, 16'sh0100, 0, 0, 0, 0);

        for (int n = 0; n < 500; n++)
        begin
            if (n == 250)
            begin
                start <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            quiet = (n >= 440);
            random_item();
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
